/* rtl/core/itda_pkg.sv */
// Package for the integer to decimal ASCII converter.
// Holds the ASCII character codes and the control struct for the digit cells.
// It depends on nothing else.
`default_nettype none

package itda_pkg;

  // ASCII codes that the converter emits.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Length codes of the length_mode input.
  localparam logic [1:0] LEN_SHORT = 2'd0;
  localparam logic [1:0] LEN_INT   = 2'd1;

  // Width of one packed decimal digit.
  localparam int unsigned DIGIT_BITS = 4;

  // Commands that every cell of the digit chain receives in the same cycle.
  typedef struct packed {
    logic clear;      // Load zero into the digit.
    logic bin_shift;  // Add three if needed, then shift one binary bit in.
    logic dig_shift;  // Take the whole digit of the lower neighbour.
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/itda_digit_cell.sv */
// One decimal digit cell of the shift-add-3 chain.
// Depends on itda_pkg for the control struct and the digit width.
`default_nettype none

module itda_digit_cell (
  input  wire logic                                clk,
  input  wire itda_pkg::cell_ctrl_t                ctrl,
  input  wire logic                                bin_in,
  input  wire logic [itda_pkg::DIGIT_BITS-1:0]     dig_in,
  output logic                                     bin_out,
  output logic [itda_pkg::DIGIT_BITS-1:0]          digit
);

  logic [itda_pkg::DIGIT_BITS-1:0] adj;

  // A digit of five or more gets three added, so that doubling carries out.
  always_comb begin
    if (digit >= 4'd5) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
  end

  assign bin_out = adj[3];

  // The digit register itself; it holds payload only and needs no reset.
  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.bin_shift) begin
      digit <= {adj[2:0], bin_in};
    end else if (ctrl.dig_shift) begin
      digit <= dig_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/integer_to_decimal_ascii.sv */
// Integer to decimal ASCII converter. An item carries a raw value, a signedness flag, a length
// code (short 16 bits, int 32 bits, long VALUE_WIDTH bits) and plus and space prefix flags; the
// block returns the decimal text one character per output item, most significant first, with
// last set on the final character. An item is loaded, then converted from binary to decimal
// in a chain of digit cells (one bit shifted through the chain per cycle); then its leading
// zero digits are skipped and its digits emitted, a sign going out ahead of the first digit.
// Output stalls can hold the emission. A new item is taken once the last character sits in
// the output register.
// Depends on itda_pkg and itda_digit_cell.
`default_nettype none

module integer_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic                   is_signed,
  input  wire logic [1:0]             length_mode,
  input  wire logic                   plus_flag,
  input  wire logic                   space_flag,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  character,
  output logic                        last
);

  // Digits needed for the largest unsigned value of VALUE_WIDTH bits.
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned INT_BITS   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned BCNT_W     = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);
  localparam int unsigned DB         = itda_pkg::DIGIT_BITS;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_CONVERT = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCNT_W-1:0]      bcnt;
  logic [DCNT_W-1:0]      dcnt;
  logic                   started;
  logic                   sign_pending;
  logic [7:0]             sign_char;

  logic [VALUE_WIDTH-1:0] val_cut;
  logic [VALUE_WIDTH-1:0] len_mask;
  logic [VALUE_WIDTH-1:0] neg_mag;
  logic                   neg;
  logic                   accept;
  logic                   out_free;
  logic                   skip;
  logic                   emit_dig;
  logic                   emit_sign;
  logic [DB-1:0]          top_digit;

  itda_pkg::cell_ctrl_t   ctrl;
  logic [DB-1:0]          digits  [NUM_DIGITS];
  logic                   carries [NUM_DIGITS];

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Cut the value to the chosen length and find its sign.
  always_comb begin
    unique case (length_mode)
      itda_pkg::LEN_SHORT: begin
        len_mask = {{(VALUE_WIDTH-16){1'b0}}, {16{1'b1}}};
        neg      = value[15];
      end
      itda_pkg::LEN_INT: begin
        len_mask = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - INT_BITS);
        neg      = value[INT_BITS-1];
      end
      default: begin
        len_mask = {VALUE_WIDTH{1'b1}};
        neg      = value[VALUE_WIDTH-1];
      end
    endcase
    val_cut = value & len_mask;
    // The most negative value negates to itself, which is its magnitude.
    neg_mag = (~val_cut + 1'b1) & len_mask;
  end

  // Chain commands and the emit decisions.
  assign top_digit = digits[NUM_DIGITS-1];
  assign skip      = (state == ST_EMIT) && !started && (top_digit == '0) && (dcnt > 1);
  assign emit_sign = (state == ST_EMIT) && sign_pending && out_free;
  assign emit_dig  = (state == ST_EMIT) && !skip && !sign_pending && out_free;

  always_comb begin
    ctrl.clear     = accept;
    ctrl.bin_shift = (state == ST_CONVERT);
    ctrl.dig_shift = skip || emit_dig;
  end

  // The row of digit cells; index zero holds the least significant digit.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      itda_digit_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bin_in  (mag[VALUE_WIDTH-1]),
        .dig_in  ({DB{1'b0}}),
        .bin_out (carries[i]),
        .digit   (digits[i])
      );
    end else begin : g_rest
      itda_digit_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bin_in  (carries[i-1]),
        .dig_in  (digits[i-1]),
        .bin_out (carries[i]),
        .digit   (digits[i])
      );
    end
  end

  // Sequencer: load, shift the magnitude through the chain, then emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bcnt         <= '0;
      dcnt         <= '0;
      started      <= 1'b0;
      sign_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state        <= ST_CONVERT;
            bcnt         <= BCNT_W'(VALUE_WIDTH);
            sign_pending <= is_signed && (neg || plus_flag || space_flag);
          end
        end
        ST_CONVERT: begin
          bcnt <= bcnt - 1'b1;
          if (bcnt == BCNT_W'(1)) begin
            state   <= ST_EMIT;
            dcnt    <= DCNT_W'(NUM_DIGITS);
            started <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (emit_sign) begin
            sign_pending <= 1'b0;
          end
          if (skip || emit_dig) begin
            dcnt <= dcnt - 1'b1;
          end
          if (emit_dig) begin
            started <= 1'b1;
            if (dcnt == DCNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Magnitude shift register and the sign character of the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= (is_signed && neg) ? neg_mag : val_cut;
      priority if (neg) begin
        sign_char <= itda_pkg::CH_MINUS;
      end else if (plus_flag) begin
        sign_char <= itda_pkg::CH_PLUS;
      end else begin
        sign_char <= itda_pkg::CH_SPACE;
      end
    end else if (state == ST_CONVERT) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  // Output register for one character item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sign || emit_dig) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      character <= sign_char;
      last      <= 1'b0;
    end else if (emit_dig) begin
      character <= itda_pkg::CH_ZERO + {{(8-DB){1'b0}}, top_digit};
      last      <= (dcnt == DCNT_W'(1));
    end
  end

  // Every character shown is a digit or one of the three prefix characters.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((character >= itda_pkg::CH_ZERO && character <= itda_pkg::CH_ZERO + 8'd9)
                   || character == itda_pkg::CH_MINUS || character == itda_pkg::CH_PLUS
                   || character == itda_pkg::CH_SPACE))
    else $error("character outside the decimal alphabet");

  // The most significant cell always holds a proper decimal digit once loaded.
  a_top_decimal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("top digit cell holds a non-decimal code");

  // An accepted item always starts the conversion in the next cycle.
  a_accept_convert: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONVERT))
    else $error("accepted item did not start conversion");

  // While emitting there is always at least one digit left to show.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (dcnt != '0))
    else $error("digit count ran out while emitting");

  // The final digit of an item carries last and returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_dig && dcnt == DCNT_W'(1)) |=> (last && out_valid && state == ST_IDLE))
    else $error("final digit not marked last");

endmodule

`default_nettype wire
